FILE: sv/hti_pkg.sv
`timescale 1ns / 1ps
// Package for the humidity and temperature interpolator: word types, register
// indexes, pipeline sizes and the divider step. No dependencies.
package hti_pkg;

   localparam int SampleBits = 16;
   localparam int DegBits    = 7;
   localparam int RemBits    = 16;
   localparam int DivBits    = 24;
   localparam int StepBits   = 2;
   localparam int DivStages  = DivBits / StepBits;
   // Difference, product and magnitude stages ahead of the divider.
   localparam int PipeStages = 3 + DivStages;
   localparam int CsrIdxBits = 3;

   typedef enum logic [CsrIdxBits-1:0] {
      CsrTempLowDeg  = 3'd0,
      CsrTempHighDeg = 3'd1,
      CsrTempLowRaw  = 3'd2,
      CsrTempHighRaw = 3'd3,
      CsrHumLowPct   = 3'd4,
      CsrHumHighPct  = 3'd5,
      CsrHumLowRaw   = 3'd6,
      CsrHumHighRaw  = 3'd7
   } hti_csr_type;

   typedef struct packed {
      logic signed [SampleBits-1:0] hum_sample;
      logic signed [SampleBits-1:0] temp_sample;
   } hti_req_type;

   typedef struct packed {
      logic signed [SampleBits-1:0] temp_deg;
      logic signed [SampleBits-1:0] hum_pct;
      logic [1:0]                   span_error;
   } hti_rsp_type;

   // Calibration of one channel.
   typedef struct packed {
      logic [DegBits-1:0]           pt0;
      logic [DegBits-1:0]           pt1;
      logic signed [SampleBits-1:0] raw0;
      logic signed [SampleBits-1:0] raw1;
   } hti_cal_type;

   // StepBits steps of restoring division. The accumulator holds the partial
   // remainder on top and the numerator bits, being replaced by quotient bits,
   // below.
   function automatic logic [RemBits+DivBits-1:0] div_step(
      input logic [RemBits+DivBits-1:0] acc,
      input logic [RemBits-1:0]         den
   );
      logic [RemBits:0]   trial;
      logic [RemBits-1:0] rem;
      logic [DivBits-1:0] nq;
      rem = acc[RemBits+DivBits-1:DivBits];
      nq  = acc[DivBits-1:0];
      for (int i = 0; i < StepBits; i++) begin
         trial = {rem, nq[DivBits-1]};
         nq    = {nq[DivBits-2:0], 1'b0};
         if (trial >= {1'b0, den}) begin
            trial = trial - {1'b0, den};
            nq[0] = 1'b1;
         end
         rem = trial[RemBits-1:0];
      end
      return {rem, nq};
   endfunction

endpackage

FILE: sv/humidity_temperature_interpolator.sv
`timescale 1ns / 1ps
// Humidity and temperature interpolator, top level: calibration registers,
// pipeline control and the result register. Uses hti_pkg and hti_chan.
//
// Usage:
//  The req channel takes one word holding a raw humidity and a raw temperature
//  sample. The rsp channel returns one word per request: temperature in degrees
//  and humidity in percent, each interpolated between two calibration points,
//  plus a flag per channel whose raw calibration span is zero (that result is 0).
//  Calibration is written through the csr port, one register per write. The user
//  must write it only while no words are in flight; the block does not enforce it.
//  From acceptance to rsp_valid a word passes the difference register, which
//  loads at acceptance, then the multiply and magnitude stages, twelve divider
//  stages of two quotient bits each, and the result register. Throughput is one
//  word per cycle while the receiver does not stall.
//  Each stage has its own valid bit; a stage takes new data when it is empty or
//  its successor moves, so bubbles close up. When the receiver stalls, the
//  result register holds and req_stall rises only once every stage is full.
//  Reset (synchronous) empties the pipeline and restores the calibration to
//  zero points with raw spans of one.
module humidity_temperature_interpolator (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  hti_pkg::hti_req_type                 req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output hti_pkg::hti_rsp_type                 rsp_data,
   input  logic                                 csr_we,
   input  logic [hti_pkg::CsrIdxBits-1:0]       csr_index,
   input  logic [hti_pkg::SampleBits-1:0]       csr_wdata
);
   import hti_pkg::*;

   hti_cal_type              temp_cal_ff;
   hti_cal_type              hum_cal_ff;

   logic [PipeStages:0]      valid_ff, valid_in;
   logic [PipeStages:0]      adv;

   logic [SampleBits-1:0]    temp_res, hum_res;
   logic                     temp_zero, hum_zero;
   hti_rsp_type              rsp_in, rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_cal_ff <= '{pt0: '0, pt1: '0, raw0: '0, raw1: SampleBits'(1)};
         hum_cal_ff  <= '{pt0: '0, pt1: '0, raw0: '0, raw1: SampleBits'(1)};
      end else if (csr_we) begin
         case (hti_csr_type'(csr_index))
            CsrTempLowDeg:  temp_cal_ff.pt0  <= csr_wdata[DegBits-1:0];
            CsrTempHighDeg: temp_cal_ff.pt1  <= csr_wdata[DegBits-1:0];
            CsrTempLowRaw:  temp_cal_ff.raw0 <= csr_wdata;
            CsrTempHighRaw: temp_cal_ff.raw1 <= csr_wdata;
            CsrHumLowPct:   hum_cal_ff.pt0   <= csr_wdata[DegBits-1:0];
            CsrHumHighPct:  hum_cal_ff.pt1   <= csr_wdata[DegBits-1:0];
            CsrHumLowRaw:   hum_cal_ff.raw0  <= csr_wdata;
            CsrHumHighRaw:  hum_cal_ff.raw1  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // A stage may load when it is empty or when its contents move on.
   always_comb begin
      adv[PipeStages] = !valid_ff[PipeStages] || !rsp_stall;
      for (int i = PipeStages - 1; i >= 0; i--) begin
         adv[i] = !valid_ff[i] || adv[i+1];
      end
      valid_in = valid_ff;
      if (adv[0]) begin
         valid_in[0] = req_valid;
      end
      for (int i = 1; i <= PipeStages; i++) begin
         if (adv[i]) begin
            valid_in[i] = valid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   hti_chan u_temp (
      .clock     (clock),
      .sample    (req_data.temp_sample),
      .cal       (temp_cal_ff),
      .en        (adv[PipeStages-1:0]),
      .result    (temp_res),
      .span_zero (temp_zero)
   );

   hti_chan u_hum (
      .clock     (clock),
      .sample    (req_data.hum_sample),
      .cal       (hum_cal_ff),
      .en        (adv[PipeStages-1:0]),
      .result    (hum_res),
      .span_zero (hum_zero)
   );

   always_comb begin
      rsp_in.temp_deg   = temp_res;
      rsp_in.hum_pct    = hum_res;
      rsp_in.span_error = {hum_zero, temp_zero};
   end

   always_ff @(posedge clock) begin
      if (adv[PipeStages]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign req_stall = !adv[0];
   assign rsp_valid = valid_ff[PipeStages];
   assign rsp_data  = rsp_ff;

endmodule

FILE: sv/hti_chan.sv
`timescale 1ns / 1ps
// Datapath of one interpolation channel: difference, product, magnitude and a
// pipelined restoring divider. Uses hti_pkg.
module hti_chan (
   input  logic                                 clock,
   input  logic signed [hti_pkg::SampleBits-1:0] sample,
   input  hti_pkg::hti_cal_type                 cal,
   input  logic [hti_pkg::PipeStages-1:0]       en,
   output logic [hti_pkg::SampleBits-1:0]       result,
   output logic                                 span_zero
);
   import hti_pkg::*;

   logic signed [SampleBits:0]   span;
   logic signed [SampleBits:0]   span_abs;
   logic [RemBits-1:0]           den;

   logic signed [SampleBits:0]   diff_in, diff_ff;
   logic signed [DegBits:0]      dpt_in, dpt_ff;
   logic signed [DivBits:0]      prod_in, prod_ff;
   logic signed [DivBits:0]      prod_abs;
   logic [DivBits-1:0]           mag_in, mag_ff;
   logic                         sign_in, sign_ff;

   logic [RemBits+DivBits-1:0]   acc_in [DivStages];
   logic [RemBits+DivBits-1:0]   acc_ff [DivStages];
   logic                         neg_in [DivStages];
   logic                         neg_ff [DivStages];

   logic [DivBits-1:0]           quot;
   logic [SampleBits-1:0]        q16;

   // Calibration must only change while the pipeline is empty (the user's rule, not enforced here); it is read live.
   assign span      = $signed({cal.raw1[SampleBits-1], cal.raw1})
                    - $signed({cal.raw0[SampleBits-1], cal.raw0});
   assign span_abs  = span[SampleBits] ? (SampleBits+1)'(-span) : span;
   assign den       = span_abs[RemBits-1:0];
   assign span_zero = (span == '0);

   always_comb begin
      diff_in  = $signed({sample[SampleBits-1], sample})
               - $signed({cal.raw0[SampleBits-1], cal.raw0});
      dpt_in   = $signed({1'b0, cal.pt1}) - $signed({1'b0, cal.pt0});
      prod_in  = diff_ff * dpt_ff;
      prod_abs = prod_ff[DivBits] ? (DivBits+1)'(-prod_ff) : prod_ff;
      mag_in   = prod_abs[DivBits-1:0];
      sign_in  = prod_ff[DivBits] ^ span[SampleBits];
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         diff_ff <= diff_in;
         dpt_ff  <= dpt_in;
      end
      if (en[1]) begin
         prod_ff <= prod_in;
      end
      if (en[2]) begin
         mag_ff  <= mag_in;
         sign_ff <= sign_in;
      end
   end

   for (genvar k = 0; k < DivStages; k++) begin : g_div
      if (k == 0) begin : g_first
         assign acc_in[k] = div_step({{RemBits{1'b0}}, mag_ff}, den);
         assign neg_in[k] = sign_ff;
      end else begin : g_rest
         assign acc_in[k] = div_step(acc_ff[k-1], den);
         assign neg_in[k] = neg_ff[k-1];
      end
      always_ff @(posedge clock) begin
         if (en[3+k]) begin
            acc_ff[k] <= acc_in[k];
            neg_ff[k] <= neg_in[k];
         end
      end
   end

   always_comb begin
      quot   = acc_ff[DivStages-1][DivBits-1:0];
      q16    = neg_ff[DivStages-1] ? (~quot[SampleBits-1:0] + SampleBits'(1))
                                   : quot[SampleBits-1:0];
      result = span_zero ? '0 : (SampleBits'(cal.pt0) + q16);
   end

endmodule

FILE: sv/hti_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the humidity and temperature interpolator, bound to
// the top level. Uses hti_pkg.
module hti_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_stall,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input hti_pkg::hti_rsp_type           rsp_data
);
   import hti_pkg::*;

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word valid right after reset");

   // A stalled result word stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result word changed");

   // With the result register free, no stage can be holding the input back.
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled while the output is empty");

   // A zero temperature span gives a zero temperature.
   a_temp_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.span_error[0] |-> rsp_data.temp_deg == '0)
      else $error("temperature nonzero on a zero span");

   // A zero humidity span gives a zero humidity.
   a_hum_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.span_error[1] |-> rsp_data.hum_pct == '0)
      else $error("humidity nonzero on a zero span");

endmodule

bind humidity_temperature_interpolator hti_checker u_hti_checker (.*);
